FILE: design/rfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rfd_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned LEN_W    = 12;
   localparam int unsigned COUNT_W  = 13;
   localparam int unsigned RECENT_W = 24;

   localparam logic [LEN_W-1:0]    LEN_RESET   = 12'd2740;
   localparam logic [COUNT_W-1:0]  HDR_LEN     = 13'd4;
   localparam logic [RECENT_W-1:0] TAIL_FIRST3 = 24'hEEFFEF;
   localparam logic [BYTE_W-1:0]   TAIL_LAST   = 8'hFE;

   localparam logic [BYTE_W-1:0] HDR_BYTES [4] = '{8'h5A, 8'hA5, 8'h55, 8'hAA};

   typedef enum logic [1:0] {
      EV_NONE     = 2'd0,
      EV_GOOD     = 2'd1,
      EV_BADLEN   = 2'd2,
      EV_MISSTAIL = 2'd3
   } frame_event_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  data_byte;
      logic               in_frame;
      logic [COUNT_W-1:0] byte_index;
      frame_event_type    frame_event;
   } result_type;

endpackage

`default_nettype wire

FILE: design/radar_frame_delimiter_top.sv
// path: a byte accepted on req is held in the s0 input register, then moves into the
// output register, which raises rsp_tvalid, once that register is free or rsp_tready is high
// throughput: one byte per cycle while rsp_tready stays high, set by the single input and output register pair
// the output register frees while rsp_tready is high, so no bubble under full flow
// reset: synchronous, active high; clears both stages, byte count and history,
// and loads frame_length with 2740
`timescale 1ns / 1ps
`default_nettype none

module radar_frame_delimiter_top
   import rfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] data_byte, [20:8] byte_index, [23:21] zero
   output logic [2:0]       rsp_tuser,   // [0] in_frame, [2:1] frame_event
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [11:0] csr_data     // [11:0] frame_length
);

   logic              s0_valid_ff;
   logic [BYTE_W-1:0] s0_byte_ff;
   logic              out_valid_ff;
   result_type        out_res_ff;
   result_type        core_res;
   logic              advance;
   logic              req_take;

   assign advance    = s0_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s0_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   rfd_frame_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg_we     (csr_valid),
      .cfg_length (csr_data),
      .step       (advance),
      .rx_byte    (s0_byte_ff),
      .result     (core_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            s0_valid_ff <= 1'b1;
         end else if (advance) begin
            s0_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s0_byte_ff <= req_tdata;
      end
      if (advance) begin
         out_res_ff <= core_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_res_ff.byte_index, out_res_ff.data_byte};
   assign rsp_tuser  = {out_res_ff.frame_event, out_res_ff.in_frame};

`ifndef SYNTH
   // a frame event only comes with a stored byte
   a_event_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (out_res_ff.frame_event != EV_NONE) |-> out_res_ff.in_frame)
      else $error("frame event on a byte outside the frame");

   // dropped bytes carry index zero
   a_drop_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !out_res_ff.in_frame |-> (out_res_ff.byte_index == '0))
      else $error("nonzero index on a dropped byte");

   // events only fire past the header
   a_event_after_header: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (out_res_ff.frame_event != EV_NONE) |-> (out_res_ff.byte_index >= HDR_LEN))
      else $error("frame event inside the header");

   // a held output with a pending byte must stall the input stage
   a_stall: assert property (@(posedge clock) disable iff (reset)
      s0_valid_ff && out_valid_ff && !rsp_tready |-> !req_tready)
      else $error("input taken while pipeline is blocked");
`endif

endmodule

`default_nettype wire

FILE: design/rfd_frame_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rfd_frame_ctrl
   import rfd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cfg_we,
   input  wire logic [LEN_W-1:0]  cfg_length,
   input  wire logic              step,
   input  wire logic [BYTE_W-1:0] rx_byte,
   output result_type             result
);

   logic [LEN_W-1:0]    frame_length_ff;
   logic [COUNT_W-1:0]  byte_count_ff, byte_count_in;
   logic [RECENT_W-1:0] recent_ff, recent_in;
   logic [COUNT_W-1:0]  count_inc;
   logic [COUNT_W-1:0]  length_ext;
   logic                tail_hit;

   assign count_inc  = byte_count_ff + 1'b1;
   assign length_ext = {1'b0, frame_length_ff};
   assign tail_hit   = (recent_ff == TAIL_FIRST3) && (rx_byte == TAIL_LAST);

   always_comb begin
      result.data_byte   = rx_byte;
      result.in_frame    = 1'b0;
      result.byte_index  = '0;
      result.frame_event = EV_NONE;
      byte_count_in      = byte_count_ff;
      recent_in          = recent_ff;
      if (byte_count_ff < HDR_LEN) begin
         // hunting or inside the header
         if (rx_byte == HDR_BYTES[byte_count_ff[1:0]]) begin
            result.in_frame   = 1'b1;
            result.byte_index = byte_count_ff;
            byte_count_in     = count_inc;
            recent_in         = {recent_ff[RECENT_W-BYTE_W-1:0], rx_byte};
         end else begin
            byte_count_in = '0;
         end
      end else begin
         result.in_frame   = 1'b1;
         result.byte_index = byte_count_ff;
         recent_in         = {recent_ff[RECENT_W-BYTE_W-1:0], rx_byte};
         if (tail_hit) begin
            result.frame_event = (count_inc == length_ext) ? EV_GOOD : EV_BADLEN;
            byte_count_in      = '0;
         end else if (count_inc > length_ext) begin
            result.frame_event = EV_MISSTAIL;
            byte_count_in      = '0;
         end else begin
            byte_count_in = count_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff <= LEN_RESET;
         byte_count_ff   <= '0;
         recent_ff       <= '0;
      end else begin
         if (cfg_we) begin
            frame_length_ff <= cfg_length;
         end
         if (step) begin
            byte_count_ff <= byte_count_in;
            recent_ff     <= recent_in;
         end
      end
   end

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import rfd_pkg::*;

   localparam int HOLD_CYCLES = 60;
   localparam int NUM_PHASES  = 8;

   // length setting, idle mode and random byte count of each phase
   localparam logic [11:0] PHASE_LEN   [NUM_PHASES] = '{12'd9, 12'd12, 12'd0, 12'd8,
                                                        12'd3, 12'd37, 12'd4095, 12'd0};
   localparam int          PHASE_MODE  [NUM_PHASES] = '{0, 0, 1, 1, 1, 1, 2, 2};
   localparam int          PHASE_BYTES [NUM_PHASES] = '{150, 100, 60, 100, 60, 120, 60, 150};

   typedef struct packed {
      logic        is_csr;
      logic [11:0] len;
      logic [7:0]  rx_byte;
      logic        known;
      result_type  want;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [11:0] csr_data;

   // frame tracker state
   logic [11:0] trk_len;
   logic [12:0] trk_count;
   logic [23:0] trk_recent;

   result_type   expected_results [$];
   plan_row_type plan [27];

   int snd_idle_pct = 0;
   int rcv_idle_pct = 0;
   bit hold_off_req = 1'b0;
   int errors       = 0;
   int bytes_sent   = 0;
   int n_settings   = 0;
   int ev_seen [4]  = '{0, 0, 0, 0};

   radar_frame_delimiter_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic result_type frame_sync_step(input logic [7:0] b);
      result_type r;
      logic       tail_seen;
      r.data_byte   = b;
      r.in_frame    = 1'b0;
      r.byte_index  = '0;
      r.frame_event = EV_NONE;
      if (trk_count < HDR_LEN) begin
         if (b == HDR_BYTES[trk_count[1:0]]) begin
            r.in_frame   = 1'b1;
            r.byte_index = trk_count;
            trk_recent   = {trk_recent[15:0], b};
            trk_count    = trk_count + 13'd1;
         end else begin
            // the failing byte is dropped, even a header start
            trk_count = '0;
         end
      end else begin
         r.in_frame   = 1'b1;
         r.byte_index = trk_count;
         tail_seen    = (trk_recent == TAIL_FIRST3) && (b == TAIL_LAST);
         trk_recent   = {trk_recent[15:0], b};
         trk_count    = trk_count + 13'd1;
         if (tail_seen) begin
            r.frame_event = (trk_count == {1'b0, trk_len}) ? EV_GOOD : EV_BADLEN;
            trk_count     = '0;
         end else if (trk_count > {1'b0, trk_len}) begin
            r.frame_event = EV_MISSTAIL;
            trk_count     = '0;
         end
      end
      return r;
   endfunction

   function automatic plan_row_type byte_row(input logic [7:0] b, input logic known = 1'b0,
                                             input logic in_f = 1'b0,
                                             input logic [12:0] idx = '0,
                                             input frame_event_type ev = EV_NONE);
      plan_row_type row;
      row.is_csr           = 1'b0;
      row.len              = '0;
      row.rx_byte          = b;
      row.known            = known;
      row.want.data_byte   = b;
      row.want.in_frame    = in_f;
      row.want.byte_index  = idx;
      row.want.frame_event = ev;
      return row;
   endfunction

   function automatic plan_row_type len_row(input logic [11:0] len);
      plan_row_type row;
      row        = '0;
      row.is_csr = 1'b1;
      row.len    = len;
      return row;
   endfunction

   function automatic logic [7:0] payload_byte();
      case ($urandom_range(15))
         0:       return TAIL_FIRST3[23:16];
         1:       return TAIL_FIRST3[15:8];
         2:       return TAIL_FIRST3[7:0];
         3:       return TAIL_LAST;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic set_idle_mode(input int mode);
      case (mode)
         0: begin
            snd_idle_pct = 30;
            rcv_idle_pct = 46;
         end
         1: begin
            snd_idle_pct = 46;
            rcv_idle_pct = 30;
         end
         default: begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
         end
      endcase
   endtask

   task automatic send_byte(input logic [7:0] b, input logic known = 1'b0,
                            input result_type want = '0);
      result_type predicted;
      while ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      predicted = frame_sync_step(b);
      expected_results.push_back(known ? want : predicted);
      bytes_sent++;
   endtask

   task automatic send_header();
      for (int k = 0; k < 4; k++) send_byte(HDR_BYTES[k]);
   endtask

   task automatic send_tail();
      send_byte(TAIL_FIRST3[23:16]);
      send_byte(TAIL_FIRST3[15:8]);
      send_byte(TAIL_FIRST3[7:0]);
      send_byte(TAIL_LAST);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_len(input logic [11:0] len);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= len;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      trk_len = len;
      n_settings++;
   endtask

   // one well-formed, short, tail-less, broken or noisy byte sequence
   task automatic random_sequence(input logic [11:0] len);
      int          kind;
      int          n;
      int          k;
      logic [7:0]  b;
      kind = $urandom_range(99);
      if (kind < 55 && len >= 12'd8 && len <= 12'd300) begin
         send_header();
         repeat (int'(len) - 8) send_byte(payload_byte());
         send_tail();
      end else if (kind < 70) begin
         send_header();
         repeat ($urandom_range(12)) send_byte(payload_byte());
         send_tail();
      end else if (kind < 80 && len <= 12'd300) begin
         // no tail byte in the payload, so the count runs past the length
         send_header();
         n = (len >= 12'd4) ? int'(len) - 3 : 1;
         repeat (n) send_byte(8'($urandom_range(8'hED)));
      end else if (kind < 90) begin
         k = $urandom_range(1, 3);
         for (int i = 0; i < k; i++) send_byte(HDR_BYTES[i]);
         do b = 8'($urandom); while (b == HDR_BYTES[k]);
         if ($urandom_range(1) == 0) b = HDR_BYTES[0];
         send_byte(b);
      end else begin
         repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(3) == 0) send_byte(HDR_BYTES[$urandom_range(3)]);
            else send_byte(payload_byte());
         end
      end
   endtask

   task automatic check_field(input string what, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
         errors++;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result transaction with none expected, expected nothing, got %h/%h",
                     $time, rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            want = expected_results.pop_front();
            check_field("data_byte", want.data_byte, rsp_tdata[7:0]);
            check_field("in_frame", want.in_frame, rsp_tuser[0]);
            check_field("byte_index", want.byte_index, rsp_tdata[20:8]);
            check_field("frame_event", want.frame_event, rsp_tuser[2:1]);
            ev_seen[want.frame_event]++;
         end
      end
   end

   // receiver, with an occasional long hold-off on request
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   initial begin
      #5_000_000;
      $display("timeout at %0t", $time);
      $display("simulation failed");
      $finish;
   end

   initial begin
      int  start;
      bit  paused;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      trk_len    = LEN_RESET;
      trk_count  = '0;
      trk_recent = '0;
      paused     = 1'b0;

      // reset length 2740 for the first frame, then the length-8 case
      plan = '{
         byte_row(8'h00, 1'b1, 1'b0, 13'd0, EV_NONE),
         byte_row(8'hFF, 1'b1, 1'b0, 13'd0, EV_NONE),
         byte_row(8'h5A, 1'b1, 1'b1, 13'd0, EV_NONE),
         byte_row(8'h5A, 1'b1, 1'b0, 13'd0, EV_NONE),
         byte_row(8'h5A, 1'b1, 1'b1, 13'd0, EV_NONE),
         byte_row(8'hA5, 1'b1, 1'b1, 13'd1, EV_NONE),
         byte_row(8'h5A, 1'b1, 1'b0, 13'd0, EV_NONE),
         byte_row(8'h5A, 1'b1, 1'b1, 13'd0, EV_NONE),
         byte_row(8'hA5, 1'b1, 1'b1, 13'd1, EV_NONE),
         byte_row(8'h55, 1'b1, 1'b1, 13'd2, EV_NONE),
         byte_row(8'h5A, 1'b1, 1'b0, 13'd0, EV_NONE),
         byte_row(8'h5A, 1'b1, 1'b1, 13'd0, EV_NONE),
         byte_row(8'hA5, 1'b1, 1'b1, 13'd1, EV_NONE),
         byte_row(8'h55, 1'b1, 1'b1, 13'd2, EV_NONE),
         byte_row(8'hAA, 1'b1, 1'b1, 13'd3, EV_NONE),
         byte_row(8'hEE),
         byte_row(8'hFF),
         byte_row(8'hEF),
         byte_row(8'hFE, 1'b1, 1'b1, 13'd7, EV_BADLEN),
         len_row(12'd8),
         byte_row(8'h5A),
         byte_row(8'hA5),
         byte_row(8'h55),
         byte_row(8'hAA),
         byte_row(8'hEE),
         byte_row(8'hFF),
         byte_row(8'hEF)
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      set_idle_mode(0);

      foreach (plan[i]) begin
         if (plan[i].is_csr) write_len(plan[i].len);
         else send_byte(plan[i].rx_byte, plan[i].known, plan[i].want);
      end
      send_byte(8'hFE, 1'b1, '{8'hFE, 1'b1, 13'd7, EV_GOOD});

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p == NUM_PHASES - 1) write_len(12'($urandom_range(13, 200)));
         else write_len(PHASE_LEN[p]);
         set_idle_mode(PHASE_MODE[p]);
         if (p == 0 || p >= 6) hold_off_req = 1'b1;
         start = bytes_sent;
         while (bytes_sent - start < PHASE_BYTES[p]) begin
            if (p == 0 && !paused && bytes_sent - start >= 70) begin
               wait_drained();
               paused = 1'b1;
            end
            random_sequence(trk_len);
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      $display("%0d bytes over %0d length settings, frame ends: %0d good, %0d wrong length",
               bytes_sent, n_settings, ev_seen[EV_GOOD], ev_seen[EV_BADLEN]);
      $display("%0d missing tail, with sender and receiver stalls and long output holds",
               ev_seen[EV_MISSTAIL]);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: files.f
design/rfd_pkg.sv
design/rfd_frame_ctrl.sv
design/radar_frame_delimiter_top.sv
bench/tb_top.sv
